// ===== hw/rtl/wsd_pkg.sv =====
// Shared types, constants and helper functions for the worker slot dispatcher.
`timescale 1ns / 1ps

package wsd_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int IDX_W     = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int THR_W     = 9;
  localparam int PROD_W    = THR_W + CNT_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = THR_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_WORKERS    = 2'd0,
    CFG_MAX_WORKERS    = 2'd1,
    CFG_BUSY_THRESHOLD = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_SUBMIT = 2'd0,
    MODE_DONE   = 2'd1,
    MODE_MANAGE = 2'd2,
    MODE_INIT   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE_USED = 3'd0,
    ST_GROWN     = 3'd1,
    ST_REJECTED  = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_NO_SHRINK = 3'd4,
    ST_SHRUNK    = 3'd5,
    ST_INIT      = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_COUNT,
    FSM_SHRINK
  } fsm_t;

  // Clamped limits handed from the register file to the sequencer.
  typedef struct packed {
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
    logic [THR_W-1:0] thr;
  } limits_t;

  function automatic logic [CNT_W-1:0] clamp_slots(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > CNT_W'(MAX_SLOTS)) begin
      r = CNT_W'(MAX_SLOTS);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // One bit for each slot below the given active count.
  function automatic logic [MAX_SLOTS-1:0] active_mask(input logic [CNT_W-1:0] n);
    logic [MAX_SLOTS-1:0] m;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      m[i] = (CNT_W'(i) < n);
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/wsd_cfg_regs.sv =====
// Configuration register file with clamping of the slot limits.
`timescale 1ns / 1ps

module wsd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [wsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wsd_pkg::CFG_DAT_W-1:0] cfg_wdata,
  output wsd_pkg::limits_t              limits
);

  logic [wsd_pkg::CNT_W-1:0] min_r, min_nxt;
  logic [wsd_pkg::CNT_W-1:0] max_r, max_nxt;
  logic [wsd_pkg::THR_W-1:0] thr_r, thr_nxt;

  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    thr_nxt = thr_r;
    if (cfg_we) begin
      case (wsd_pkg::cfg_idx_t'(cfg_index))
        wsd_pkg::CFG_MIN_WORKERS:    min_nxt = cfg_wdata[wsd_pkg::CNT_W-1:0];
        wsd_pkg::CFG_MAX_WORKERS:    max_nxt = cfg_wdata[wsd_pkg::CNT_W-1:0];
        wsd_pkg::CFG_BUSY_THRESHOLD: thr_nxt = cfg_wdata[wsd_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= wsd_pkg::CNT_W'(4);
      max_r <= wsd_pkg::CNT_W'(16);
      thr_r <= wsd_pkg::THR_W'(128);
    end else begin
      min_r <= min_nxt;
      max_r <= max_nxt;
      thr_r <= thr_nxt;
    end
  end

  assign limits.lo  = wsd_pkg::clamp_slots(min_r);
  assign limits.hi  = wsd_pkg::clamp_slots(max_r);
  assign limits.thr = thr_r;

endmodule

// ===== hw/rtl/worker_slot_dispatcher.sv =====
// Top level: first-idle job dispatch over an elastic pool of worker slots.
// Each command walks the active slots, one per cycle through a single counter and compare:
// a submit scans for the lowest idle slot and then counts the busy slots, a done, an init or
// a manage tick counts them, and a manage tick under the threshold then drops idle slots from
// the top. Busy drops in the result cycle, so the next command can be taken in that cycle.
`timescale 1ns / 1ps

module worker_slot_dispatcher (
  input  logic                          clk,
  input  logic                          rst_n,
  // Command channel.
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_mode,
  input  logic [wsd_pkg::IDX_W-1:0]     in_done_slot,
  // Result channel: one strobe cycle per transfer, the receiver cannot stall it.
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic [wsd_pkg::IDX_W-1:0]     out_slot,
  output logic [wsd_pkg::CNT_W-1:0]     out_active_count,
  output logic [wsd_pkg::CNT_W-1:0]     out_busy_count,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [wsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wsd_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  wsd_pkg::limits_t limits;

  wsd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .limits    (limits)
  );

  // Sequencer state and the pool itself. Bits of busy_map at or above the
  // active count are always zero, so shrinking never has to clear anything.
  // Reset (synchronous, rst_n low) clears the pool to zero active slots, all idle.
  wsd_pkg::fsm_t                 state_r, state_nxt;
  wsd_pkg::mode_t                mode_r, mode_nxt;
  wsd_pkg::status_t              status_r, status_nxt;
  logic [wsd_pkg::IDX_W-1:0]     slot_r, slot_nxt;
  logic [wsd_pkg::CNT_W-1:0]     idx_r, idx_nxt;
  logic [wsd_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [wsd_pkg::MAX_SLOTS-1:0] busy_map_r, busy_map_nxt;
  logic [wsd_pkg::CNT_W-1:0]     active_r, active_nxt;

  logic                          out_valid_r, out_valid_nxt;
  wsd_pkg::status_t              out_status_r, out_status_nxt;
  logic [wsd_pkg::IDX_W-1:0]     out_slot_r, out_slot_nxt;
  logic [wsd_pkg::CNT_W-1:0]     out_active_r, out_active_nxt;
  logic [wsd_pkg::CNT_W-1:0]     out_busy_r, out_busy_nxt;

  // The shared walking unit: one slot index, its busy bit, and a compare
  // of the index against the active count.
  logic [wsd_pkg::IDX_W-1:0]     walk_idx;
  logic                          walk_in_range;
  logic                          walk_bit;
  logic [wsd_pkg::IDX_W-1:0]     top_idx;
  logic [wsd_pkg::PROD_W-1:0]    busy_scaled;
  logic [wsd_pkg::PROD_W-1:0]    thr_scaled;
  logic                          accept;

  assign walk_idx      = idx_r[wsd_pkg::IDX_W-1:0];
  assign walk_in_range = (idx_r < active_r);
  assign walk_bit      = busy_map_r[walk_idx];
  assign top_idx       = wsd_pkg::IDX_W'(active_r - wsd_pkg::CNT_W'(1));
  assign busy_scaled   = wsd_pkg::PROD_W'({cnt_r, 8'd0});
  assign thr_scaled    = wsd_pkg::PROD_W'(limits.thr) * wsd_pkg::PROD_W'(active_r);
  assign accept        = start && (state_r == wsd_pkg::FSM_IDLE);

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    status_nxt     = status_r;
    slot_nxt       = slot_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    busy_map_nxt   = busy_map_r;
    active_nxt     = active_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_active_nxt = out_active_r;
    out_busy_nxt   = out_busy_r;

    case (state_r)
      wsd_pkg::FSM_IDLE: begin
        if (accept) begin
          mode_nxt = wsd_pkg::mode_t'(in_mode);
          slot_nxt = '0;
          idx_nxt  = '0;
          cnt_nxt  = '0;
          case (wsd_pkg::mode_t'(in_mode))
            wsd_pkg::MODE_SUBMIT: begin
              state_nxt = wsd_pkg::FSM_SCAN;
            end
            wsd_pkg::MODE_DONE: begin
              // A done on a slot outside the pool changes nothing.
              if (wsd_pkg::CNT_W'(in_done_slot) < active_r) begin
                busy_map_nxt[in_done_slot] = 1'b0;
              end
              status_nxt = wsd_pkg::ST_RELEASED;
              state_nxt  = wsd_pkg::FSM_COUNT;
            end
            wsd_pkg::MODE_MANAGE: begin
              status_nxt = wsd_pkg::ST_NO_SHRINK;
              state_nxt  = wsd_pkg::FSM_COUNT;
            end
            default: begin
              active_nxt   = limits.lo;
              busy_map_nxt = '0;
              status_nxt   = wsd_pkg::ST_INIT;
              state_nxt    = wsd_pkg::FSM_COUNT;
            end
          endcase
        end
      end

      wsd_pkg::FSM_SCAN: begin
        // Look for the lowest idle active slot, one slot per cycle.
        if (walk_in_range) begin
          if (!walk_bit) begin
            busy_map_nxt[walk_idx] = 1'b1;
            status_nxt = wsd_pkg::ST_IDLE_USED;
            slot_nxt   = walk_idx;
            idx_nxt    = '0;
            state_nxt  = wsd_pkg::FSM_COUNT;
          end else begin
            idx_nxt = idx_r + wsd_pkg::CNT_W'(1);
          end
        end else begin
          // Every active slot is busy: grow by one busy slot or reject.
          if (active_r < limits.hi) begin
            busy_map_nxt[active_r[wsd_pkg::IDX_W-1:0]] = 1'b1;
            slot_nxt   = active_r[wsd_pkg::IDX_W-1:0];
            active_nxt = active_r + wsd_pkg::CNT_W'(1);
            status_nxt = wsd_pkg::ST_GROWN;
          end else begin
            slot_nxt   = '0;
            status_nxt = wsd_pkg::ST_REJECTED;
          end
          idx_nxt   = '0;
          state_nxt = wsd_pkg::FSM_COUNT;
        end
      end

      wsd_pkg::FSM_COUNT: begin
        // Count busy active slots, one slot per cycle.
        if (walk_in_range) begin
          cnt_nxt = cnt_r + wsd_pkg::CNT_W'(walk_bit);
          idx_nxt = idx_r + wsd_pkg::CNT_W'(1);
        end else if (mode_r == wsd_pkg::MODE_MANAGE && active_r != '0 &&
                     busy_scaled < thr_scaled) begin
          // The pool is under the threshold: try to drop idle slots from the top.
          state_nxt = wsd_pkg::FSM_SHRINK;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_slot_nxt   = slot_r;
          out_active_nxt = active_r;
          out_busy_nxt   = cnt_r;
          state_nxt      = wsd_pkg::FSM_IDLE;
        end
      end

      wsd_pkg::FSM_SHRINK: begin
        // Only idle slots are dropped, so the busy count stays as counted.
        if (active_r > limits.lo && !busy_map_r[top_idx]) begin
          active_nxt = active_r - wsd_pkg::CNT_W'(1);
          status_nxt = wsd_pkg::ST_SHRUNK;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_slot_nxt   = slot_r;
          out_active_nxt = active_r;
          out_busy_nxt   = cnt_r;
          state_nxt      = wsd_pkg::FSM_IDLE;
        end
      end

      default: begin
        state_nxt = wsd_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wsd_pkg::FSM_IDLE;
      busy_map_r  <= '0;
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_map_r  <= busy_map_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    status_r     <= status_nxt;
    slot_r       <= slot_nxt;
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_active_r <= out_active_nxt;
    out_busy_r   <= out_busy_nxt;
  end

  assign busy             = (state_r != wsd_pkg::FSM_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot         = out_slot_r;
  assign out_active_count = out_active_r;
  assign out_busy_count   = out_busy_r;

`ifndef SYNTHESIS
  // No slot outside the active range is ever marked busy.
  a_no_busy_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_map_r & ~wsd_pkg::active_mask(active_r)) == '0)
    else $error("busy bit set outside the active range");

  // The pool never exceeds the slot count.
  a_active_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    active_r <= wsd_pkg::CNT_W'(wsd_pkg::MAX_SLOTS))
    else $error("active count above the slot count");

  // A result strobe lasts a single cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

  // A reported busy count never exceeds the reported active count.
  a_busy_le_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_busy_r <= out_active_r)
    else $error("busy count above active count");

  // A grown pool hands out its new top slot.
  a_grown_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == wsd_pkg::ST_GROWN) |->
      (wsd_pkg::CNT_W'(out_slot_r) + wsd_pkg::CNT_W'(1) == out_active_r))
    else $error("grown slot is not the top active slot");
`endif

endmodule
